// ===== src/kptmm_pkg.sv =====
// ----------------------------------------------------------------------------
// kptmm_pkg
// Types shared by the keyed price table: channel payloads, the token that
// sweeps the cell chain, and the control states.
// ----------------------------------------------------------------------------
package kptmm_pkg;

    localparam int unsigned StampW = 32;
    localparam int unsigned PriceW = 32;

    typedef struct packed {
        logic [StampW-1:0] stamp;
        logic [PriceW-1:0] price_in;
    } kptmm_item_t;

    typedef struct packed {
        logic [PriceW-1:0] latest_price;
        logic [PriceW-1:0] max_price;
        logic [PriceW-1:0] min_price;
        logic              dropped_full;
    } kptmm_result_t;

    // Sweep token, handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [StampW-1:0] stamp;
        logic [PriceW-1:0] price;
        logic [StampW-1:0] newest;
        logic              hit;
        logic              seen;
        logic [PriceW-1:0] hi;
        logic [PriceW-1:0] lo;
        logic [PriceW-1:0] cur;
    } kptmm_token_t;

    typedef enum logic {
        KPTMM_IDLE,
        KPTMM_SWEEP
    } kptmm_state_t;

endpackage

// ===== src/keyed_price_table_min_max_top.sv =====
// ----------------------------------------------------------------------------
// keyed_price_table_min_max_top
// Timestamp-keyed price table with latest, max and min price per update.
// ----------------------------------------------------------------------------
// Sweep: the accepted item is registered as the start token, which walks
//   the cell chain one cell per cycle through the live entries and the first
//   free cell, at most CAPACITY cells. A new item is taken only once the
//   sweep has ended and the queue has room; a two-deep result queue lets the
//   next item in while a result waits.
// Reset: asynchronous, active low; table empties at once, newest stamp is 0.
// ----------------------------------------------------------------------------
module keyed_price_table_min_max_top
    import kptmm_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  kptmm_item_t   item,
    output logic          result_valid,
    input  logic          result_ready,
    output kptmm_result_t result
);

    // Chain wiring: tok[i] enters cell i, tok[CAPACITY] leaves the last cell
    kptmm_token_t  tok [CAPACITY+1];
    kptmm_result_t cell_res [CAPACITY];
    logic [CAPACITY-1:0] cell_res_valid;
    logic [CAPACITY-1:0] cell_occupied;

    kptmm_state_t state_reg;
    kptmm_state_t state_next;

    kptmm_token_t      start_reg;
    kptmm_token_t      start_next;
    logic [StampW-1:0] newest_reg;
    logic [StampW-1:0] newest_next;

    kptmm_result_t q0_reg, q0_next;
    kptmm_result_t q1_reg, q1_next;
    logic [1:0]    count_reg, count_next;

    logic          accept;
    logic          full;
    logic          fin_valid;
    kptmm_result_t fin;
    logic          push;
    logic          pop;

    // ---- control ----------------------------------------------------------
    // Only one item sweeps at a time; the queue must have room for its result
    assign accept = item_valid && item_ready;
    // Entries are never removed and fill from the bottom: top cell marks full
    assign full   = cell_occupied[CAPACITY-1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            KPTMM_IDLE:
            begin
                if (accept)
                begin
                    state_next = KPTMM_SWEEP;
                end
            end
            KPTMM_SWEEP:
            begin
                if (fin_valid)
                begin
                    state_next = KPTMM_IDLE;
                end
            end
            default:
            begin
                state_next = KPTMM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        unique case (state_reg)
            KPTMM_IDLE:  item_ready = (count_reg != 2'd2);
            KPTMM_SWEEP: item_ready = 1'b0;
            default:     item_ready = 1'b0;
        endcase
    end

    // ---- sweep launch -----------------------------------------------------
    // Newest stamp can be settled up front: a full table with a known stamp
    // never raises it, a full table with a new stamp drops the record.
    always_comb
    begin
        newest_next = newest_reg;
        if (accept && !full && (item.stamp > newest_reg))
        begin
            newest_next = item.stamp;
        end

        start_next        = start_reg;
        start_next.valid  = accept;
        start_next.stamp  = item.stamp;
        start_next.price  = item.price_in;
        start_next.newest = newest_next;
        start_next.hit    = 1'b0;
        start_next.seen   = 1'b0;
        start_next.hi     = '0;
        start_next.lo     = '0;
        start_next.cur    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= KPTMM_IDLE;
            newest_reg <= '0;
            start_reg  <= '0;
            count_reg  <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
            if (accept)
            begin
                start_reg <= start_next;
            end
            else
            begin
                start_reg.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    // ---- cell chain -------------------------------------------------------
    assign tok[0] = start_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        kptmm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (tok[g]),
            .tok_out   (tok[g+1]),
            .res       (cell_res[g]),
            .res_valid (cell_res_valid[g]),
            .occupied  (cell_occupied[g])
        );
    end

    // ---- sweep completion -------------------------------------------------
    // Ends either at the first free cell (one-hot, results pre-masked) or by
    // running off the top of a full table, where a miss means a drop.
    always_comb
    begin
        fin       = '0;
        fin_valid = tok[CAPACITY].valid;
        if (tok[CAPACITY].valid)
        begin
            fin.latest_price = tok[CAPACITY].cur;
            fin.max_price    = tok[CAPACITY].hi;
            fin.min_price    = tok[CAPACITY].lo;
            fin.dropped_full = !tok[CAPACITY].hit;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            fin       = fin | cell_res[i];
            fin_valid = fin_valid | cell_res_valid[i];
        end
    end

    // ---- result queue, two deep -------------------------------------------
    assign result_valid = (count_reg != 2'd0);
    assign result       = q0_reg;
    assign push         = fin_valid;
    assign pop          = result_valid && result_ready;

    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};

        if (pop && (count_reg == 2'd2))
        begin
            q0_next = q1_reg;
        end
        else if (push && ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop)))
        begin
            q0_next = fin;
        end

        if (push && (((count_reg == 2'd1) && !pop) || ((count_reg == 2'd2) && pop)))
        begin
            q1_next = fin;
        end
    end

endmodule

// ===== src/kptmm_cell.sv =====
// ----------------------------------------------------------------------------
// kptmm_cell
// One table entry. Updates itself when the sweep token passes, folds its
// price into the running max/min/latest, and ends the sweep if it was free.
// ----------------------------------------------------------------------------
module kptmm_cell
    import kptmm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  kptmm_token_t  tok_in,
    output kptmm_token_t  tok_out,
    output kptmm_result_t res,
    output logic          res_valid,
    output logic          occupied
);

    logic [StampW-1:0] stamp_reg;
    logic [PriceW-1:0] price_reg;
    logic              valid_reg;
    logic              valid_next;

    kptmm_token_t  tok_reg;
    kptmm_token_t  tok_next;
    kptmm_result_t res_reg;
    kptmm_result_t res_next;
    logic          res_valid_reg;
    logic          res_valid_next;

    logic              match;
    logic              fill;
    logic              live;
    logic [PriceW-1:0] price_eff;
    logic [StampW-1:0] stamp_eff;

    always_comb
    begin
        match     = tok_in.valid && valid_reg && (stamp_reg == tok_in.stamp);
        // entries fill from the bottom, so the first free cell is the slot
        fill      = tok_in.valid && !valid_reg && !tok_in.hit;
        live      = valid_reg || fill;
        price_eff = (match || fill) ? tok_in.price : price_reg;
        stamp_eff = fill ? tok_in.stamp : stamp_reg;
        valid_next = valid_reg || fill;

        tok_next       = tok_in;
        tok_next.valid = tok_in.valid && valid_reg;
        tok_next.hit   = tok_in.hit || match;
        if (live)
        begin
            tok_next.seen = 1'b1;
            if (!tok_in.seen)
            begin
                tok_next.hi = price_eff;
                tok_next.lo = price_eff;
            end
            else
            begin
                tok_next.hi = (price_eff > tok_in.hi) ? price_eff : tok_in.hi;
                tok_next.lo = (price_eff < tok_in.lo) ? price_eff : tok_in.lo;
            end
            if (stamp_eff == tok_in.newest)
            begin
                tok_next.cur = price_eff;
            end
        end

        // a free cell ends the sweep: nothing above it is live
        res_valid_next        = tok_in.valid && !valid_reg;
        res_next.latest_price = tok_next.cur;
        res_next.max_price    = tok_next.hi;
        res_next.min_price    = tok_next.lo;
        res_next.dropped_full = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            tok_reg       <= tok_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (match || fill)
        begin
            price_reg <= tok_in.price;
        end
        if (fill)
        begin
            stamp_reg <= tok_in.stamp;
        end
        res_reg        <= res_next;
    end

    assign tok_out   = tok_reg;
    assign res       = res_valid_reg ? res_reg : '0;
    assign res_valid = res_valid_reg;
    assign occupied  = valid_reg;

endmodule

// ===== tb/sv/keyed_price_table_min_max_top_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_price_table_min_max_top_tb
// Self-checking bench for the keyed price table. Price records go in over a
// valid/ready channel with random gaps. A behavioural copy of the table works
// out the latest, highest and lowest price and the drop flag for every record
// at its transfer. Each result transfer is checked against the oldest of them.
// ----------------------------------------------------------------------------
module keyed_price_table_min_max_top_tb
    import kptmm_pkg::*;
;

    localparam int unsigned CAPACITY    = 64;
    localparam int          ITEM_TARGET = 1600;
    localparam int          HOLD_CYCLES = 400;
    localparam int          STALL_LIMIT = 4000;
    // Stamps stay at or below this while the table fills, so that a record dropped
    // later can still carry a stamp above the newest one.
    localparam logic [31:0] FILL_CEIL   = 32'hFFFE_FFFF;

    // Which live cell a known stamp is taken from
    typedef enum int {
        PICK_ANY,
        PICK_NEWEST,
        PICK_HIGHEST,
        PICK_LOWEST
    } pick_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          item_valid = 1'b0;
    logic          item_ready;
    kptmm_item_t   item = '0;
    logic          result_valid;
    logic          result_ready = 1'b0;
    kptmm_result_t result;

    // Behavioural copy of the price table
    logic [31:0]   book_stamp [CAPACITY];
    logic [31:0]   book_price [CAPACITY];
    logic          book_live  [CAPACITY];
    logic [31:0]   book_newest = '0;
    int            book_count  = 0;

    kptmm_result_t quotes_due [$];
    kptmm_result_t quote_head;
    int            err_count  = 0;
    int            sent_count = 0;

    // Sender and receiver pacing
    int            tx_calm_left = 0;
    bit            tx_calm      = 1'b0;
    bit            tx_no_gap    = 1'b0;
    int            rx_calm_left = 0;
    bit            rx_calm      = 1'b0;
    int            rx_stall_left = 0;
    int            rx_hold_left = 0;
    bit            rx_hold_req  = 1'b0;
    int            idle_cycles  = 0;

    keyed_price_table_min_max_top #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #6 clk = ~clk;

    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            book_live[i]  = 1'b0;
            book_stamp[i] = '0;
            book_price[i] = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Table behaviour: update by key, track the newest stamp, then reduce
    // over every live cell. Returns the result this record must produce.
    // ------------------------------------------------------------------------
    function automatic kptmm_result_t book_quote(input logic [31:0] s,
                                                 input logic [31:0] p);
        kptmm_result_t r;
        int            i;
        int            hit_at;
        int            free_at;
        logic          seen;
        r       = '0;
        hit_at  = -1;
        free_at = -1;
        seen    = 1'b0;
        for (i = 0; i < CAPACITY; i++)
        begin
            if (book_live[i])
            begin
                if (hit_at < 0 && book_stamp[i] == s)
                    hit_at = i;
            end
            else if (free_at < 0)
                free_at = i;
        end
        if (hit_at >= 0)
            book_price[hit_at] = p;
        else if (free_at >= 0)
        begin
            // lowest free cell takes a new stamp
            book_stamp[free_at] = s;
            book_price[free_at] = p;
            book_live[free_at]  = 1'b1;
            book_count++;
        end
        else
            r.dropped_full = 1'b1;
        // a dropped record must not move the newest stamp
        if (!r.dropped_full && s > book_newest)
            book_newest = s;
        for (i = 0; i < CAPACITY; i++)
        begin
            if (book_live[i])
            begin
                if (!seen)
                begin
                    r.max_price = book_price[i];
                    r.min_price = book_price[i];
                    seen        = 1'b1;
                end
                else
                begin
                    if (book_price[i] > r.max_price)
                        r.max_price = book_price[i];
                    if (book_price[i] < r.min_price)
                        r.min_price = book_price[i];
                end
                if (book_stamp[i] == book_newest)
                    r.latest_price = book_price[i];
            end
        end
        return r;
    endfunction

    function automatic bit stamp_known(input logic [31:0] s);
        for (int i = 0; i < CAPACITY; i++)
            if (book_live[i] && book_stamp[i] == s)
                return 1'b1;
        return 1'b0;
    endfunction

    // Only called with at least one live cell
    function automatic int random_live_cell();
        int i;
        do
            i = $urandom_range(0, CAPACITY - 1);
        while (!book_live[i]);
        return i;
    endfunction

    function automatic logic [31:0] known_stamp(input pick_t how);
        int i;
        int at;
        at = random_live_cell();
        if (how == PICK_NEWEST)
            return book_newest;
        for (i = 0; i < CAPACITY; i++)
        begin
            if (book_live[i])
            begin
                if (how == PICK_HIGHEST && book_price[i] > book_price[at])
                    at = i;
                if (how == PICK_LOWEST && book_price[i] < book_price[at])
                    at = i;
            end
        end
        return book_stamp[at];
    endfunction

    function automatic pick_t random_pick();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return PICK_NEWEST;
        if (r == 1)
            return PICK_HIGHEST;
        if (r == 2)
            return PICK_LOWEST;
        return PICK_ANY;
    endfunction

    // New stamp at or below ceil: a step past the newest, one below it,
    // anywhere, or the ceiling itself
    function automatic logic [31:0] fresh_stamp(input logic [31:0] ceil);
        logic [31:0] s;
        int          r;
        do
        begin
            r = $urandom_range(0, 9);
            if (r < 4 && book_newest <= ceil - 32'd1000)
                s = book_newest + $urandom_range(1, 1000);
            else if (r < 7 && book_newest != '0)
                s = $urandom % book_newest;
            else if (r == 9)
                s = ceil;
            else
                s = $urandom_range(0, ceil);
        end
        while (stamp_known(s));
        return s;
    endfunction

    // Extremes, small values for ties, copies of live prices, and noise
    function automatic logic [31:0] random_price();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5 && book_count > 0)
            return book_price[random_live_cell()];
        if (r < 7)
            return $urandom_range(0, 15);
        return $urandom;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one record per call. Valid stays high on return so that a
    // back-to-back record follows without a dip; the expectation is booked
    // at the edge of the transfer.
    // ------------------------------------------------------------------------
    task automatic send_quote(input logic [31:0] s, input logic [31:0] p);
        kptmm_item_t q;
        int          gap;
        if (tx_calm_left == 0)
        begin
            tx_calm_left = $urandom_range(20, 150);
            tx_calm      = ($urandom_range(0, 2) == 0);
        end
        tx_calm_left--;
        gap = (tx_calm || tx_no_gap) ? 0 : random_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        q.stamp    = s;
        q.price_in = p;
        item_valid <= 1'b1;
        item       <= q;
        do
            @(posedge clk);
        while (!item_ready);
        quotes_due.push_back(book_quote(s, p));
        sent_count++;
    endtask

    task automatic pause_until_drained();
        item_valid <= 1'b0;
        while (quotes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: checks each result transfer, then chooses the next ready.
    // A long hold-off is counted here once a test asks for it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (quotes_due.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result: expected none, actual %h", $time, result);
            end
            else
            begin
                quote_head = quotes_due.pop_front();
                compare_field("latest_price", quote_head.latest_price, result.latest_price);
                compare_field("max_price", quote_head.max_price, result.max_price);
                compare_field("min_price", quote_head.min_price, result.min_price);
                compare_field("dropped_full", {31'd0, quote_head.dropped_full},
                              {31'd0, result.dropped_full});
            end
        end

        if (!rst_n)
            result_ready <= 1'b0;
        else if (rx_hold_req)
        begin
            rx_hold_req  = 1'b0;
            rx_hold_left = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            result_ready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            if (rx_calm_left == 0)
            begin
                rx_calm_left = $urandom_range(20, 200);
                rx_calm      = ($urandom_range(0, 2) == 0);
            end
            rx_calm_left--;
            rx_stall_left = rx_calm ? 0 : random_gap();
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer on either side ends the run
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and bit patterns on an empty table. Stamp zero first,
    // so the newest stamp starts out matching a live cell; an overwrite of a
    // cell; an older stamp that must not move the newest one.
    task automatic test_extremes();
        send_quote(32'h0000_0000, 32'h0000_0000);
        send_quote(32'h0000_0000, 32'hFFFF_FFFF);
        send_quote(32'h0000_0010, 32'h0000_0000);
        send_quote(32'h0000_0001, 32'h0001_2345);
        send_quote(32'h0000_0010, 32'hFFFF_FFFF);
        send_quote(32'h0000_0000, 32'h0000_0000);
        send_quote(32'h7FFF_FFFF, 32'h8000_0000);
        send_quote(32'h8000_0000, 32'h7FFF_FFFF);
        send_quote(32'h5555_5555, 32'hAAAA_AAAA);
        send_quote(32'hAAAA_AAAA, 32'h5555_5555);
        send_quote(32'h8000_0000, 32'h8000_0000);
        send_quote(32'h0000_0001, 32'h0000_0001);
        send_quote(32'hAAAA_AAAA, 32'hFFFF_FFFE);
    endtask

    // Receiver holds off while the sender keeps offering back to back, so
    // the result queue fills and the input side stalls.
    task automatic test_backpressure();
        tx_no_gap   = 1'b1;
        rx_hold_req = 1'b1;
        repeat (12)
        begin
            if ($urandom_range(0, 1) == 0)
                send_quote(fresh_stamp(FILL_CEIL), random_price());
            else
                send_quote(known_stamp(random_pick()), random_price());
        end
        tx_no_gap = 1'b0;
    endtask

    // Random traffic, mostly overwrites, until one cell is left free
    task automatic test_fill_table();
        while (book_count < CAPACITY - 1)
        begin
            if (book_count == 0 || $urandom_range(0, 9) < 3)
                send_quote(fresh_stamp(FILL_CEIL), random_price());
            else
                send_quote(known_stamp(random_pick()), random_price());
        end
    endtask

    // Sender pauses until every result is back, then the last cell is taken
    // and new stamps are dropped while known ones still overwrite.
    task automatic test_full_table();
        logic [31:0] s;
        pause_until_drained();
        send_quote(book_newest + 32'd7, random_price());
        // new stamp above the newest: dropped, newest must not move
        send_quote(book_newest + 32'd1, 32'h0000_0000);
        send_quote(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        do
            s = $urandom % book_newest;
        while (stamp_known(s));
        send_quote(s, 32'h0000_0000);
        send_quote(known_stamp(PICK_NEWEST), 32'hFFFF_FFFF);
        send_quote(known_stamp(PICK_LOWEST), 32'hFFFF_FFF0);
        send_quote(known_stamp(PICK_HIGHEST), 32'h0000_0000);
        send_quote(known_stamp(PICK_NEWEST), 32'h0000_0000);
    endtask

    // Full table from here on: overwrites mixed with dropped new stamps
    task automatic test_random_full();
        while (sent_count < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 35)
                send_quote(fresh_stamp(32'hFFFF_FFFF), random_price());
            else
                send_quote(known_stamp(random_pick()), random_price());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_backpressure();
        test_fill_table();
        test_full_table();
        test_random_full();

        // drain, then leave room for any stray result transfer
        pause_until_drained();
        repeat (CAPACITY + 20) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
src/kptmm_pkg.sv
src/kptmm_cell.sv
src/keyed_price_table_min_max_top.sv
tb/sv/keyed_price_table_min_max_top_tb.sv
